// ===== sv/gnd_pkg.sv =====
// Shared types, constants and defaults for the gather_nd engine.
package gnd_pkg;

    localparam int STORE_DEPTH_DEF    = 4096;
    localparam int MAX_INDEX_RANK_DEF = 4;
    localparam int MAX_INNER_DEF      = 64;
    localparam int ELEMENT_WIDTH_DEF  = 32;

    localparam int NUM_IDX     = 4;
    localparam int IDX_W       = 32;
    localparam int DIM_W       = 13;
    localparam int RANK_W      = 3;
    localparam int INNER_W     = 7;
    localparam int DATA_W      = 32;
    localparam int LOAD_ADDR_W = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 13;
    localparam int IN_TDATA_W  = 176;
    localparam int OUT_TDATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INDEX_RANK   = 3'd0,
        REG_DIM_SIZE_0   = 3'd1,
        REG_DIM_SIZE_1   = 3'd2,
        REG_DIM_SIZE_2   = 3'd3,
        REG_DIM_SIZE_3   = 3'd4,
        REG_INNER_LENGTH = 3'd5
    } cfg_reg_t;

    // metadata of one store read, aligned with the read data
    typedef struct packed {
        logic vld;
        logic bad;
        logic last;
    } rd_req_t;

endpackage

// ===== sv/gnd_ram.sv =====
// Generic simple dual-port RAM with registered read.
module gnd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/gnd_seq.sv =====
// Row computation and store read sequencer for gather items.
module gnd_seq #(
    parameter int STORE_DEPTH    = gnd_pkg::STORE_DEPTH_DEF,
    parameter int MAX_INDEX_RANK = gnd_pkg::MAX_INDEX_RANK_DEF,
    parameter int MAX_INNER      = gnd_pkg::MAX_INNER_DEF
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  logic                                              start,
    input  logic [gnd_pkg::NUM_IDX-1:0][gnd_pkg::IDX_W-1:0]   idx_in,
    input  logic [gnd_pkg::RANK_W-1:0]                        rank_cfg,
    input  logic [gnd_pkg::NUM_IDX-1:0][gnd_pkg::DIM_W-1:0]   dim_cfg,
    input  logic [gnd_pkg::INNER_W-1:0]                       inner_cfg,
    input  logic                                              can_issue,
    output logic                                              idle,
    output logic                                              rd_en,
    output logic [$clog2(STORE_DEPTH)-1:0]                    rd_addr,
    output gnd_pkg::rd_req_t                                  rd_req
);

    localparam int AW  = $clog2(STORE_DEPTH);
    localparam int PW  = AW + gnd_pkg::DIM_W;
    localparam int BW  = AW + gnd_pkg::INNER_W;
    localparam int SW  = $clog2(gnd_pkg::NUM_IDX);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_STEP  = 5'b00010,
        ST_BASE  = 5'b00100,
        ST_CHECK = 5'b01000,
        ST_EMIT  = 5'b10000
    } seq_state_t;

    seq_state_t                                     state_reg, state_next;
    logic [gnd_pkg::NUM_IDX-1:0][gnd_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [gnd_pkg::RANK_W-1:0]                     rank_reg, rank_next;
    logic [gnd_pkg::INNER_W-1:0]                    inner_reg, inner_next;
    logic [SW-1:0]                                  step_reg, step_next;
    logic [AW-1:0]                                  row_reg, row_next;
    logic                                           bad_reg, bad_next;
    logic [BW-1:0]                                  base_reg, base_next;
    logic [gnd_pkg::INNER_W-1:0]                    cnt_reg, cnt_next;
    gnd_pkg::rd_req_t                               req_reg, req_next;

    logic [gnd_pkg::RANK_W-1:0]  eff_rank;
    logic [gnd_pkg::INNER_W-1:0] eff_inner;
    logic [gnd_pkg::IDX_W-1:0]   cur_idx;
    logic [gnd_pkg::DIM_W-1:0]   cur_dim;
    logic                        idx_ok;
    logic [PW-1:0]               prod;
    logic [PW:0]                 sum;
    logic                        fits;
    logic [BW:0]                 slice_end;
    logic [BW-1:0]               addr_full;
    logic                        last_elem;

    always_comb begin
        eff_rank = rank_cfg;
        if (eff_rank == '0) begin
            eff_rank = gnd_pkg::RANK_W'(1);
        end
        if (32'(eff_rank) > 32'(gnd_pkg::NUM_IDX)) begin
            eff_rank = gnd_pkg::RANK_W'(gnd_pkg::NUM_IDX);
        end
        if (32'(eff_rank) > 32'(MAX_INDEX_RANK)) begin
            eff_rank = gnd_pkg::RANK_W'(MAX_INDEX_RANK);
        end
        eff_inner = inner_cfg;
        if (eff_inner == '0) begin
            eff_inner = gnd_pkg::INNER_W'(1);
        end
        if (32'(eff_inner) > 32'(MAX_INNER)) begin
            eff_inner = gnd_pkg::INNER_W'(MAX_INNER);
        end
    end

    // Horner step: row = row * dim[j] + idx[j]; the item is marked bad on an index out of range or a row past the store
    assign cur_idx   = idx_reg[step_reg];
    assign cur_dim   = dim_cfg[step_reg];
    assign idx_ok    = cur_idx < gnd_pkg::IDX_W'(cur_dim);
    assign prod      = PW'(row_reg) * PW'(cur_dim);
    assign sum       = (PW+1)'(prod) + (PW+1)'(cur_idx[gnd_pkg::DIM_W-1:0]);
    assign fits      = sum < (PW+1)'(STORE_DEPTH);
    assign slice_end = (BW+1)'(base_reg) + (BW+1)'(inner_reg);
    assign addr_full = base_reg + BW'(cnt_reg);
    assign last_elem = cnt_reg == (inner_reg - gnd_pkg::INNER_W'(1));

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        rank_next  = rank_reg;
        inner_next = inner_reg;
        step_next  = step_reg;
        row_next   = row_reg;
        bad_next   = bad_reg;
        base_next  = base_reg;
        cnt_next   = cnt_reg;
        req_next   = '0;
        rd_en      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    idx_next   = idx_in;
                    rank_next  = eff_rank;
                    inner_next = eff_inner;
                    step_next  = '0;
                    row_next   = '0;
                    bad_next   = 1'b0;
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                if (!idx_ok || !fits) begin
                    bad_next = 1'b1;
                end
                row_next  = AW'(sum);
                step_next = step_reg + SW'(1);
                if (gnd_pkg::RANK_W'(step_reg) == rank_reg - gnd_pkg::RANK_W'(1)) begin
                    state_next = ST_BASE;
                end
            end
            ST_BASE: begin
                base_next  = BW'(row_reg) * BW'(inner_reg);
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (slice_end > (BW+1)'(STORE_DEPTH)) begin
                    bad_next = 1'b1;
                end
                cnt_next   = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (can_issue) begin
                    rd_en         = 1'b1;
                    req_next.vld  = 1'b1;
                    req_next.bad  = bad_reg;
                    req_next.last = last_elem;
                    cnt_next      = cnt_reg + gnd_pkg::INNER_W'(1);
                    if (last_elem) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            req_reg   <= '0;
        end else begin
            state_reg <= state_next;
            req_reg   <= req_next;
        end
        idx_reg   <= idx_next;
        rank_reg  <= rank_next;
        inner_reg <= inner_next;
        step_reg  <= step_next;
        row_reg   <= row_next;
        bad_reg   <= bad_next;
        base_reg  <= base_next;
        cnt_reg   <= cnt_next;
    end

    assign idle    = state_reg == ST_IDLE;
    assign rd_addr = addr_full[AW-1:0];
    assign rd_req  = req_reg;

endmodule

// ===== sv/gnd_out.sv =====
// Output register with skid stage and read credit for the result channel.
module gnd_out #(
    parameter int ELEMENT_WIDTH = gnd_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  gnd_pkg::rd_req_t                rd_req,
    input  logic [ELEMENT_WIDTH-1:0]        rd_data,
    output logic                            can_issue,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gnd_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tuser,
    output logic                            m_tlast
);

    typedef struct packed {
        logic [gnd_pkg::DATA_W-1:0] data;
        logic                       bad;
        logic                       last;
    } out_item_t;

    out_item_t out_reg, out_next, skid_reg, skid_next, in_item;
    logic      out_v_reg, out_v_next, skid_v_reg, skid_v_next;
    logic      pop;
    logic [1:0] occ;

    assign in_item.data = rd_req.bad ? '0 : gnd_pkg::DATA_W'(rd_data);
    assign in_item.bad  = rd_req.bad;
    assign in_item.last = rd_req.last;

    assign pop = out_v_reg && m_tready;
    assign occ = 2'(out_v_reg) + 2'(skid_v_reg) + 2'(rd_req.vld);
    // at most two results outstanding, counting the read in flight
    assign can_issue = (occ < 2'd2) || (occ == 2'd2 && pop);

    always_comb begin
        out_next    = out_reg;
        out_v_next  = out_v_reg;
        skid_next   = skid_reg;
        skid_v_next = skid_v_reg;
        if (!out_v_reg || pop) begin
            if (skid_v_reg) begin
                out_next    = skid_reg;
                out_v_next  = 1'b1;
                skid_next   = in_item;
                skid_v_next = rd_req.vld;
            end else begin
                out_next    = in_item;
                out_v_next  = rd_req.vld;
            end
        end else if (rd_req.vld) begin
            skid_next   = in_item;
            skid_v_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg.data;
    assign m_tuser  = out_reg.bad;
    assign m_tlast  = out_reg.last;

endmodule

// ===== sv/gather_nd_engine_core.sv =====
// Gather engine: element store, configuration registers, sequencer and output stage.
// A load transfer leaves the input ready; a gather holds it off until the sequencer is idle.
// A slice's first element follows the step, base, check and emit states and the store read.
// Slice elements stream at one per cycle unless the output stalls, via the single read port.
// Reset (synchronous, active low) clears control state and sets the registers to rank 1,
// every dimension 1, inner length 1; store contents stay undefined, with no clearing pass.
module gather_nd_engine_core #(
    parameter int STORE_DEPTH    = gnd_pkg::STORE_DEPTH_DEF,
    parameter int MAX_INDEX_RANK = gnd_pkg::MAX_INDEX_RANK_DEF,
    parameter int MAX_INNER      = gnd_pkg::MAX_INNER_DEF,
    parameter int ELEMENT_WIDTH  = gnd_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [gnd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gnd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // load_addr[11:0], load_data[43:12], index_0[75:44], index_1[107:76],
    // index_2[139:108], index_3[171:140], zero pad
    input  logic [gnd_pkg::IN_TDATA_W-1:0]  s_tdata,
    // op
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_data[31:0]
    output logic [gnd_pkg::OUT_TDATA_W-1:0] m_tdata,
    // out_of_range
    output logic                            m_tuser,
    output logic                            m_tlast
);

    localparam int AW = $clog2(STORE_DEPTH);

    logic [gnd_pkg::RANK_W-1:0]                      rank_reg;
    logic [gnd_pkg::NUM_IDX-1:0][gnd_pkg::DIM_W-1:0] dim_reg;
    logic [gnd_pkg::INNER_W-1:0]                     inner_reg;

    logic                                            accept;
    logic [gnd_pkg::LOAD_ADDR_W-1:0]                 load_addr;
    logic [gnd_pkg::DATA_W-1:0]                      load_data;
    logic [gnd_pkg::NUM_IDX-1:0][gnd_pkg::IDX_W-1:0] idx_in;
    logic                                            wr_en;
    logic                                            seq_idle;
    logic                                            can_issue;
    logic                                            rd_en;
    logic [AW-1:0]                                   rd_addr;
    logic [ELEMENT_WIDTH-1:0]                        rd_data;
    gnd_pkg::rd_req_t                                rd_req;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_reg  <= gnd_pkg::RANK_W'(1);
            dim_reg   <= {gnd_pkg::NUM_IDX{gnd_pkg::DIM_W'(1)}};
            inner_reg <= gnd_pkg::INNER_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                gnd_pkg::REG_INDEX_RANK:   rank_reg   <= cfg_wdata[gnd_pkg::RANK_W-1:0];
                gnd_pkg::REG_DIM_SIZE_0:   dim_reg[0] <= cfg_wdata;
                gnd_pkg::REG_DIM_SIZE_1:   dim_reg[1] <= cfg_wdata;
                gnd_pkg::REG_DIM_SIZE_2:   dim_reg[2] <= cfg_wdata;
                gnd_pkg::REG_DIM_SIZE_3:   dim_reg[3] <= cfg_wdata;
                gnd_pkg::REG_INNER_LENGTH: inner_reg  <= cfg_wdata[gnd_pkg::INNER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_tready  = seq_idle;
    assign accept    = s_tvalid && s_tready;
    assign load_addr = s_tdata[11:0];
    assign load_data = s_tdata[43:12];
    assign idx_in    = s_tdata[171:44];
    assign wr_en     = accept && !s_tuser && (32'(load_addr) < 32'(STORE_DEPTH));

    gnd_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (AW'(load_addr)),
        .wr_data (ELEMENT_WIDTH'(load_data)),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    gnd_seq #(
        .STORE_DEPTH    (STORE_DEPTH),
        .MAX_INDEX_RANK (MAX_INDEX_RANK),
        .MAX_INNER      (MAX_INNER)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept && s_tuser),
        .idx_in    (idx_in),
        .rank_cfg  (rank_reg),
        .dim_cfg   (dim_reg),
        .inner_cfg (inner_reg),
        .can_issue (can_issue),
        .idle      (seq_idle),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_req    (rd_req)
    );

    gnd_out #(
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_req    (rd_req),
        .rd_data   (rd_data),
        .can_issue (can_issue),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== sv/gnd_checker.sv =====
// Port-level assertions for the gather engine, bound to the top level.
module gnd_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [gnd_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                            m_tuser,
    input logic                            m_tlast
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("out-of-range result carries data");

    a_gather_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("input ready right after gather transfer");

endmodule

bind gather_nd_engine_core gnd_checker u_checker (.*);
